/* design/hpac_pkg.sv */
// hpac_pkg: shared types and constants of the heater panel alarm controller
// event codes, timer commands, register indexes, reset values and payload structs
// no dependencies
`default_nettype none

package hpac_pkg;

    // alarm list geometry
    localparam int AlarmSlotsDefault = 4;
    localparam int ListShown         = 4;
    localparam int CountOutMax       = 7;

    // reset values of registers and state
    localparam logic [10:0] SetpointMaxRst    = 11'd1100;
    localparam logic [7:0]  SetpointStepRst   = 8'd5;
    localparam logic [7:0]  SetpointMarginRst = 8'd10;
    localparam logic [7:0]  AlarmMinMaxRst    = 8'd90;
    localparam logic [11:0] SetpointRst       = 12'd370;

    // event kinds
    localparam logic [2:0] EV_RUN_STOP = 3'd0;
    localparam logic [2:0] EV_ALARM    = 3'd1;
    localparam logic [2:0] EV_ADD      = 3'd2;
    localparam logic [2:0] EV_SUB      = 3'd3;
    localparam logic [2:0] EV_SAMPLE   = 3'd4;
    localparam logic [2:0] EV_TICK     = 3'd5;

    // button status codes
    localparam logic [1:0] BTN_NONE = 2'd0;
    localparam logic [1:0] BTN_TAP  = 2'd1;
    localparam logic [1:0] BTN_HELD = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_SETPOINT_MAX    = 2'd0;
    localparam logic [1:0] REG_SETPOINT_STEP   = 2'd1;
    localparam logic [1:0] REG_SETPOINT_MARGIN = 2'd2;
    localparam logic [1:0] REG_ALARM_MIN_MAX   = 2'd3;

    typedef enum logic [1:0] {
        TCMD_NONE    = 2'd0,
        TCMD_ENABLE  = 2'd1,
        TCMD_RESTART = 2'd2,
        TCMD_DISABLE = 2'd3
    } t_timer_cmd;

    typedef struct packed {
        logic [10:0] setpoint_max;
        logic [7:0]  setpoint_step;
        logic [7:0]  setpoint_margin;
        logic [7:0]  alarm_minutes_max;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [1:0]  button_status;
        logic [15:0] temp_sample;
    } t_event;

    typedef struct packed {
        logic        running;
        logic        led_on;
        logic        buzzer_blinking;
        t_timer_cmd  timer_command;
        logic [11:0] setpoint;
        logic [15:0] measured_temp;
        logic [2:0]  alarm_count;
        logic [31:0] alarm_list;
        logic        display_update;
    } t_result;

endpackage

`default_nettype wire

/* design/hpac_if.sv */
// hpac_if: request channels of the heater panel alarm controller
// event input, result output and register write channels
`default_nettype none

interface hpac_event_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_kind;
    logic [1:0]  button_status;
    logic [15:0] temp_sample;

    modport source (output valid, output event_kind, output button_status,
                    output temp_sample, input ready);
    modport sink   (input valid, input event_kind, input button_status,
                    input temp_sample, output ready);
endinterface

interface hpac_result_if;
    logic        valid;
    logic        ready;
    logic        running;
    logic        led_on;
    logic        buzzer_blinking;
    logic [1:0]  timer_command;
    logic [11:0] setpoint;
    logic [15:0] measured_temp;
    logic [2:0]  alarm_count;
    logic [31:0] alarm_list;
    logic        display_update;

    modport source (output valid, output running, output led_on, output buzzer_blinking,
                    output timer_command, output setpoint, output measured_temp,
                    output alarm_count, output alarm_list, output display_update,
                    input ready);
    modport sink   (input valid, input running, input led_on, input buzzer_blinking,
                    input timer_command, input setpoint, input measured_temp,
                    input alarm_count, input alarm_list, input display_update,
                    output ready);
endinterface

interface hpac_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [10:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* design/hpac_cfg_regs.sv */
// hpac_cfg_regs: configuration registers of the heater panel alarm controller
// takes write requests from the register channel; uses hpac_pkg, hpac_if
`default_nettype none

module hpac_cfg_regs (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    hpac_cfg_if.sink          i_cfg,
    output hpac_pkg::t_cfg    o_cfg
);

    hpac_pkg::t_cfg r_cfg;
    hpac_pkg::t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (i_cfg.index)
                hpac_pkg::REG_SETPOINT_MAX:    n_cfg.setpoint_max      = i_cfg.data;
                hpac_pkg::REG_SETPOINT_STEP:   n_cfg.setpoint_step     = i_cfg.data[7:0];
                hpac_pkg::REG_SETPOINT_MARGIN: n_cfg.setpoint_margin   = i_cfg.data[7:0];
                hpac_pkg::REG_ALARM_MIN_MAX:   n_cfg.alarm_minutes_max = i_cfg.data[7:0];
                default:                       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.setpoint_max      <= hpac_pkg::SetpointMaxRst;
            r_cfg.setpoint_step     <= hpac_pkg::SetpointStepRst;
            r_cfg.setpoint_margin   <= hpac_pkg::SetpointMarginRst;
            r_cfg.alarm_minutes_max <= hpac_pkg::AlarmMinMaxRst;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* design/hpac_engine.sv */
// hpac_engine: panel state and the single-pass update for one event
// holds mode, setpoint, measured value and the countdown list; uses hpac_pkg
`default_nettype none

module hpac_engine #(
    parameter int ALARM_SLOTS = hpac_pkg::AlarmSlotsDefault
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire hpac_pkg::t_event  i_event,
    input  wire hpac_pkg::t_cfg    i_cfg,
    output hpac_pkg::t_result      o_result
);

    localparam int CW = $clog2(ALARM_SLOTS + 1);

    logic              r_run;
    logic              r_held;
    logic [11:0]       r_setpoint;
    logic [15:0]       r_measured;
    logic [7:0]        r_list [ALARM_SLOTS];
    logic [CW-1:0]     r_count;
    logic              r_led;
    logic              r_buzzer;

    logic              n_run;
    logic              n_held;
    logic [11:0]       n_setpoint;
    logic [15:0]       n_measured;
    logic [7:0]        n_list [ALARM_SLOTS];
    logic [CW-1:0]     n_count;
    logic              n_led;
    logic              n_buzzer;

    hpac_pkg::t_timer_cmd tcmd;
    logic              disp;

    logic [ALARM_SLOTS-1:0] is_last;
    logic [ALARM_SLOTS-1:0] is_ext;
    logic [ALARM_SLOTS-1:0] is_app;
    logic              last_one;
    logic              ext_ok;
    logic              head_one;
    logic              btn_any;
    logic              btn_press;
    logic              btn_held;
    logic              count_nz;
    logic              count_full;
    logic [12:0]       sp_sum;
    logic [16:0]       sp_floor;
    logic [31:0]       list_pk;
    logic [CW+2:0]     cnt_ext;
    logic              tail_clear;

    // per-entry position flags against the fill count
    always_comb begin
        last_one   = 1'b0;
        ext_ok     = 1'b0;
        tail_clear = 1'b1;
        for (int i = 0; i < ALARM_SLOTS; i++) begin
            is_last[i] = (r_count == CW'(i + 1));
            is_app[i]  = (r_count == CW'(i));
            // extension goes to entry one whenever two or more are present
            is_ext[i]  = (r_count == CW'(1)) ? (i == 0) : (i == 1);
            last_one   = last_one | (is_last[i] & (r_list[i] == 8'd1));
            ext_ok     = ext_ok | (is_ext[i] & (r_list[i] < i_cfg.alarm_minutes_max));
            if (r_count <= CW'(i)) begin
                tail_clear = tail_clear & (r_list[i] == 8'd0);
            end
        end
    end

    assign head_one   = (r_list[0] == 8'd1);
    assign btn_any    = (i_event.button_status != hpac_pkg::BTN_NONE);
    assign btn_press  = (i_event.button_status == hpac_pkg::BTN_TAP);
    assign btn_held   = (i_event.button_status == hpac_pkg::BTN_HELD);
    assign count_nz   = (r_count != '0);
    assign count_full = (r_count == CW'(ALARM_SLOTS));
    assign sp_sum     = {1'b0, r_setpoint} + {5'd0, btn_any ? i_cfg.setpoint_step : 8'd0};
    assign sp_floor   = {1'b0, r_measured} + {9'd0, i_cfg.setpoint_margin};

    always_comb begin
        n_run      = r_run;
        n_held     = r_held;
        n_setpoint = r_setpoint;
        n_measured = r_measured;
        n_list     = r_list;
        n_count    = r_count;
        n_led      = r_led;
        n_buzzer   = r_buzzer;
        tcmd       = hpac_pkg::TCMD_NONE;
        disp       = 1'b0;

        if (i_event.event_kind == hpac_pkg::EV_SAMPLE) begin
            n_measured = i_event.temp_sample;
            disp       = 1'b1;
        end else if (!r_run) begin
            case (i_event.event_kind)
                hpac_pkg::EV_RUN_STOP: begin
                    if (btn_any) begin
                        n_run = 1'b1;
                        n_led = 1'b1;
                        if (count_nz) begin
                            tcmd = hpac_pkg::TCMD_ENABLE;
                        end
                    end
                end
                hpac_pkg::EV_ADD: begin
                    if (btn_any && ({1'b0, r_setpoint} < {2'b00, i_cfg.setpoint_max})) begin
                        n_setpoint = sp_sum[11:0];
                        disp       = 1'b1;
                    end
                end
                hpac_pkg::EV_SUB: begin
                    if (btn_any && ({5'd0, r_setpoint} > sp_floor)) begin
                        n_setpoint = (r_setpoint > {4'd0, i_cfg.setpoint_step}) ?
                                     r_setpoint - {4'd0, i_cfg.setpoint_step} : 12'd0;
                        disp       = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end else begin
            case (i_event.event_kind)
                hpac_pkg::EV_RUN_STOP: begin
                    if (btn_any) begin
                        n_run    = 1'b0;
                        tcmd     = hpac_pkg::TCMD_DISABLE;
                        n_buzzer = 1'b0;
                        n_led    = 1'b0;
                    end
                end
                hpac_pkg::EV_ALARM: begin
                    n_buzzer = 1'b0;
                    if (btn_held) begin
                        n_held = 1'b1;
                    end else if (!btn_any) begin
                        n_held = 1'b0;
                    end
                end
                hpac_pkg::EV_ADD: begin
                    n_buzzer = 1'b0;
                    if (r_held) begin
                        // append a one-minute entry behind the last one
                        if (btn_press && count_nz && !count_full) begin
                            for (int i = 0; i < ALARM_SLOTS; i++) begin
                                if (is_app[i]) begin
                                    n_list[i] = 8'd1;
                                end
                            end
                            n_count = r_count + CW'(1);
                            disp    = 1'b1;
                        end
                    end else if (btn_any) begin
                        if (!count_nz) begin
                            n_list[0] = 8'd1;
                            n_count   = CW'(1);
                            tcmd      = hpac_pkg::TCMD_RESTART;
                            disp      = 1'b1;
                        end else if (ext_ok) begin
                            for (int i = 0; i < ALARM_SLOTS; i++) begin
                                if (is_ext[i]) begin
                                    n_list[i] = r_list[i] + 8'd1;
                                end
                            end
                            tcmd = hpac_pkg::TCMD_RESTART;
                            disp = 1'b1;
                        end
                    end
                end
                hpac_pkg::EV_SUB: begin
                    n_buzzer = 1'b0;
                    if (r_held) begin
                        if (btn_press && count_nz) begin
                            for (int i = 0; i < ALARM_SLOTS; i++) begin
                                if (is_last[i]) begin
                                    n_list[i] = 8'd0;
                                end
                            end
                            n_count = r_count - CW'(1);
                            disp    = 1'b1;
                        end
                    end else if (btn_any && count_nz) begin
                        for (int i = 0; i < ALARM_SLOTS; i++) begin
                            if (is_last[i]) begin
                                n_list[i] = r_list[i] - 8'd1;
                            end
                        end
                        if (last_one) begin
                            n_count = r_count - CW'(1);
                            if (r_count == CW'(1)) begin
                                tcmd = hpac_pkg::TCMD_DISABLE;
                            end
                        end else begin
                            tcmd = hpac_pkg::TCMD_RESTART;
                        end
                        disp = 1'b1;
                    end
                end
                hpac_pkg::EV_TICK: begin
                    if (count_nz) begin
                        if (head_one) begin
                            // head expired: entries past the count are zero, so shift all
                            for (int i = 0; i < ALARM_SLOTS - 1; i++) begin
                                n_list[i] = r_list[i + 1];
                            end
                            n_list[ALARM_SLOTS-1] = 8'd0;
                            n_count  = r_count - CW'(1);
                            n_buzzer = 1'b1;
                        end else begin
                            n_list[0] = r_list[0] - 8'd1;
                        end
                        disp = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    for (genvar g = 0; g < hpac_pkg::ListShown; g++) begin : g_pack
        if (g < ALARM_SLOTS) begin : g_used
            assign list_pk[8*g +: 8] = n_list[g];
        end else begin : g_empty
            assign list_pk[8*g +: 8] = 8'd0;
        end
    end

    assign cnt_ext = (CW+3)'(n_count);

    always_comb begin
        o_result.running         = n_run;
        o_result.led_on          = n_led;
        o_result.buzzer_blinking = n_buzzer;
        o_result.timer_command   = tcmd;
        o_result.setpoint        = n_setpoint;
        o_result.measured_temp   = n_measured;
        o_result.alarm_count     = (cnt_ext > (CW+3)'(hpac_pkg::CountOutMax)) ?
                                   3'(hpac_pkg::CountOutMax) : cnt_ext[2:0];
        o_result.alarm_list      = list_pk;
        o_result.display_update  = disp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run      <= 1'b1;
            r_held     <= 1'b0;
            r_setpoint <= hpac_pkg::SetpointRst;
            r_measured <= 16'd0;
            for (int i = 0; i < ALARM_SLOTS; i++) begin
                r_list[i] <= 8'd0;
            end
            r_count    <= '0;
            r_led      <= 1'b0;
            r_buzzer   <= 1'b0;
        end else if (i_fire) begin
            r_run      <= n_run;
            r_held     <= n_held;
            r_setpoint <= n_setpoint;
            r_measured <= n_measured;
            r_list     <= n_list;
            r_count    <= n_count;
            r_led      <= n_led;
            r_buzzer   <= n_buzzer;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ALARM_SLOTS))
        else $error("countdown count above slot count");

    a_tail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tail_clear)
        else $error("entry past the count is not zero");

    a_stop_keeps_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && !r_run) |=> $stable(r_count) && ($past(r_list[0]) == r_list[0]))
        else $error("countdown list changed in stop mode");

    a_expiry_buzz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && r_run && i_event.event_kind == hpac_pkg::EV_TICK && count_nz && head_one)
        |=> r_buzzer && (r_count == $past(r_count) - CW'(1)))
        else $error("expired head did not drop and start the buzzer");

endmodule

`default_nettype wire

/* design/heater_panel_alarm_controller.sv */
// heater_panel_alarm_controller: top level with input register and result register
// uses hpac_pkg, hpac_if, hpac_cfg_regs, hpac_engine
//
//   port     dir  role           payload
//   i_evt    in   event request  event_kind, button_status, temp_sample
//   o_res    out  result request mode, led, buzzer, timer command, display values
//   i_cfg    in   register write index (2 bits), data (11 bits)
//
// an event is captured in the input register, then updated into the state and the
// result register by the single update stage between the two registers; one event per
// cycle throughput while the result is not stalled.
// a stalled result holds the update stage; the input register still takes one event.
// reset (synchronous, active low) restores the mode, setpoint and empty countdown list
// and the register reset values. register writes are always ready.
`default_nettype none

module heater_panel_alarm_controller #(
    parameter int ALARM_SLOTS = hpac_pkg::AlarmSlotsDefault
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    hpac_event_if.sink   i_evt,
    hpac_result_if.source o_res,
    hpac_cfg_if.sink     i_cfg
);

    hpac_pkg::t_cfg    cfg;
    hpac_pkg::t_event  r_in_item;
    logic              r_in_valid;
    hpac_pkg::t_result r_out_res;
    logic              r_out_valid;
    hpac_pkg::t_result res;
    logic              advance;
    logic              fire;

    assign advance     = !r_out_valid || o_res.ready;
    assign fire        = r_in_valid && advance;
    assign i_evt.ready = !r_in_valid || advance;

    hpac_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    hpac_engine #(
        .ALARM_SLOTS (ALARM_SLOTS)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_event  (r_in_item),
        .i_cfg    (cfg),
        .o_result (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_evt.valid && i_evt.ready) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_evt.valid && i_evt.ready) begin
            r_in_item.event_kind    <= i_evt.event_kind;
            r_in_item.button_status <= i_evt.button_status;
            r_in_item.temp_sample   <= i_evt.temp_sample;
        end
        if (fire) begin
            r_out_res <= res;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.running         = r_out_res.running;
    assign o_res.led_on          = r_out_res.led_on;
    assign o_res.buzzer_blinking = r_out_res.buzzer_blinking;
    assign o_res.timer_command   = r_out_res.timer_command;
    assign o_res.setpoint        = r_out_res.setpoint;
    assign o_res.measured_temp   = r_out_res.measured_temp;
    assign o_res.alarm_count     = r_out_res.alarm_count;
    assign o_res.alarm_list      = r_out_res.alarm_list;
    assign o_res.display_update  = r_out_res.display_update;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// tb_top: self-checking bench for heater_panel_alarm_controller, event and result
// streams with random gaps and stalls, predicted results checked field by field
// depends on hpac_pkg, hpac_if and the controller rtl
`default_nettype none

module tb_top;
    import hpac_pkg::*;

    localparam int AlarmSlots    = AlarmSlotsDefault;
    localparam int RandomPerPhase = 120;
    localparam int PhaseCount    = 6;
    localparam int WatchdogLimit = 3000;
    localparam int DrainCycles   = 6;

    // codes outside the named button and event sets
    localparam logic [1:0] BTN_ODD  = 2'd3;
    localparam logic [2:0] EV_SPARE_LO = 3'd6;
    localparam logic [2:0] EV_SPARE_HI = 3'd7;

    typedef enum logic [1:0] {
        RX_FLOW,
        RX_COIN,
        RX_SPARSE,
        RX_MOSTLY
    } t_rx_pattern;

    logic clk;
    logic rst_n;

    hpac_event_if  evt_ch ();
    hpac_result_if res_ch ();
    hpac_cfg_if    cfg_ch ();

    heater_panel_alarm_controller #(
        .ALARM_SLOTS(AlarmSlots)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_evt  (evt_ch),
        .o_res  (res_ch),
        .i_cfg  (cfg_ch)
    );

    // panel state as the bench sees it
    t_cfg        pm_cfg;
    logic        pm_running;
    logic        pm_alarm_held;
    logic        pm_led;
    logic        pm_buzzer;
    logic [11:0] pm_setpoint;
    logic [15:0] pm_measured;
    logic [7:0]  pm_minutes [AlarmSlots];
    int          pm_count;

    t_event  panel_events [$];
    t_result expected_results [$];

    int evt_offered;
    int evt_accepted;
    int results_seen;
    int mismatch_count;
    int idle_cycles;

    int burst_left;
    int gap_left;

    t_rx_pattern rx_pattern;
    int          rx_pattern_left;
    int          rx_hold_left;
    int          rx_holds_done;
    int          rx_next_hold;

    always #5 clk = ~clk;

    function automatic void reset_panel();
        pm_cfg = '{setpoint_max: SetpointMaxRst, setpoint_step: SetpointStepRst,
                   setpoint_margin: SetpointMarginRst, alarm_minutes_max: AlarmMinMaxRst};
        pm_running    = 1'b1;
        pm_alarm_held = 1'b0;
        pm_led        = 1'b0;
        pm_buzzer     = 1'b0;
        pm_setpoint   = SetpointRst;
        pm_measured   = '0;
        pm_count      = 0;
        for (int i = 0; i < AlarmSlots; i++) pm_minutes[i] = '0;
    endfunction

    // remove one countdown, later ones move up
    function automatic void drop_minute(input int pos);
        if (pm_count == 0 || pos >= pm_count) return;
        for (int i = pos; i + 1 < pm_count; i++) pm_minutes[i] = pm_minutes[i + 1];
        pm_count--;
        pm_minutes[pm_count] = '0;
    endfunction

    function automatic t_result panel_update(input t_event ev);
        t_result    r;
        t_timer_cmd tcmd;
        logic       disp;
        logic       pressed;
        logic [7:0] v;
        int         idx;
        tcmd    = TCMD_NONE;
        disp    = 1'b0;
        pressed = (ev.button_status != BTN_NONE);
        if (ev.event_kind == EV_SAMPLE) begin
            pm_measured = ev.temp_sample;
            disp = 1'b1;
        end else if (!pm_running) begin
            case (ev.event_kind)
                EV_RUN_STOP: begin
                    if (pressed) begin
                        pm_running = 1'b1;
                        pm_led = 1'b1;
                        if (pm_count > 0) tcmd = TCMD_ENABLE;
                    end
                end
                EV_ADD: begin
                    if (pressed && pm_setpoint < {1'b0, pm_cfg.setpoint_max}) begin
                        pm_setpoint = pm_setpoint + {4'b0, pm_cfg.setpoint_step};
                        disp = 1'b1;
                    end
                end
                EV_SUB: begin
                    if (pressed && int'(pm_setpoint) >
                            int'(pm_measured) + int'(pm_cfg.setpoint_margin)) begin
                        pm_setpoint = (pm_setpoint > {4'b0, pm_cfg.setpoint_step}) ?
                                      pm_setpoint - {4'b0, pm_cfg.setpoint_step} : '0;
                        disp = 1'b1;
                    end
                end
                default: ;
            endcase
        end else begin
            case (ev.event_kind)
                EV_RUN_STOP: begin
                    if (pressed) begin
                        pm_running = 1'b0;
                        tcmd = TCMD_DISABLE;
                        pm_buzzer = 1'b0;
                        pm_led = 1'b0;
                    end
                end
                EV_ALARM: begin
                    pm_buzzer = 1'b0;
                    if (ev.button_status == BTN_HELD) pm_alarm_held = 1'b1;
                    else if (ev.button_status == BTN_NONE) pm_alarm_held = 1'b0;
                end
                EV_ADD: begin
                    pm_buzzer = 1'b0;
                    if (pm_alarm_held) begin
                        if (ev.button_status == BTN_TAP && pm_count > 0 &&
                                pm_count < AlarmSlots) begin
                            pm_minutes[pm_count] = 8'd1;
                            pm_count++;
                            disp = 1'b1;
                        end
                    end else if (pressed) begin
                        if (pm_count == 0) begin
                            pm_minutes[0] = 8'd1;
                            pm_count = 1;
                            tcmd = TCMD_RESTART;
                            disp = 1'b1;
                        end else begin
                            // with two or more entries the second one is extended
                            idx = (pm_count == 1) ? 0 : 1;
                            if (pm_minutes[idx] < pm_cfg.alarm_minutes_max) begin
                                pm_minutes[idx] = pm_minutes[idx] + 8'd1;
                                tcmd = TCMD_RESTART;
                                disp = 1'b1;
                            end
                        end
                    end
                end
                EV_SUB: begin
                    pm_buzzer = 1'b0;
                    if (pm_alarm_held) begin
                        if (ev.button_status == BTN_TAP && pm_count > 0) begin
                            drop_minute(pm_count - 1);
                            disp = 1'b1;
                        end
                    end else if (pressed && pm_count > 0) begin
                        idx = pm_count - 1;
                        v = pm_minutes[idx] - 8'd1;
                        if (v == 8'd0) begin
                            drop_minute(idx);
                            if (pm_count == 0) tcmd = TCMD_DISABLE;
                        end else begin
                            pm_minutes[idx] = v;
                            tcmd = TCMD_RESTART;
                        end
                        disp = 1'b1;
                    end
                end
                EV_TICK: begin
                    if (pm_count > 0) begin
                        v = pm_minutes[0] - 8'd1;
                        if (v == 8'd0) begin
                            drop_minute(0);
                            pm_buzzer = 1'b1;
                        end else begin
                            pm_minutes[0] = v;
                        end
                        disp = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        r.running         = pm_running;
        r.led_on          = pm_led;
        r.buzzer_blinking = pm_buzzer;
        r.timer_command   = tcmd;
        r.setpoint        = pm_setpoint;
        r.measured_temp   = pm_measured;
        r.alarm_count     = (pm_count > CountOutMax) ? 3'(CountOutMax) : 3'(pm_count);
        r.alarm_list      = '0;
        for (int i = 0; i < AlarmSlots && i < ListShown; i++)
            r.alarm_list[8 * i +: 8] = pm_minutes[i];
        r.display_update  = disp;
        return r;
    endfunction

    function automatic void queue_event(input logic [2:0] kind, input logic [1:0] st,
                                        input logic [15:0] temp);
        t_event ev;
        ev.event_kind    = kind;
        ev.button_status = st;
        ev.temp_sample   = temp;
        panel_events.push_back(ev);
    endfunction

    function automatic t_event random_event();
        t_event ev;
        int     pick;
        int     st_pick;
        pick    = $urandom_range(0, 99);
        st_pick = $urandom_range(0, 9);
        if (pick < 6)       ev.event_kind = EV_RUN_STOP;
        else if (pick < 18) ev.event_kind = EV_ALARM;
        else if (pick < 48) ev.event_kind = EV_ADD;
        else if (pick < 68) ev.event_kind = EV_SUB;
        else if (pick < 78) ev.event_kind = EV_SAMPLE;
        else if (pick < 97) ev.event_kind = EV_TICK;
        else
            ev.event_kind = ($urandom_range(0, 1) != 0) ? EV_SPARE_LO : EV_SPARE_HI;
        if (st_pick == 0)      ev.button_status = BTN_NONE;
        else if (st_pick == 1) ev.button_status = BTN_ODD;
        else if (st_pick < 7)  ev.button_status = BTN_TAP;
        else                   ev.button_status = BTN_HELD;
        // mostly low temperatures so the setpoint can move down
        if (ev.event_kind == EV_SAMPLE && $urandom_range(0, 3) != 0)
            ev.temp_sample = 16'($urandom_range(0, 600));
        else
            ev.temp_sample = 16'($urandom);
        return ev;
    endfunction

    function automatic t_cfg random_cfg();
        t_cfg c;
        c.setpoint_max      = 11'($urandom_range(0, 2047));
        c.setpoint_step     = 8'($urandom_range(1, 255));
        c.setpoint_margin   = 8'($urandom_range(0, 255));
        c.alarm_minutes_max = 8'($urandom_range(1, 255));
        return c;
    endfunction

    task automatic wait_drained();
        while (panel_events.size() != 0 || evt_offered != evt_accepted ||
               expected_results.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic write_config(input t_cfg c);
        logic [1:0]  reg_idx [4];
        logic [10:0] reg_val [4];
        reg_idx = '{REG_SETPOINT_MAX, REG_SETPOINT_STEP, REG_SETPOINT_MARGIN, REG_ALARM_MIN_MAX};
        reg_val = '{c.setpoint_max, {3'b0, c.setpoint_step}, {3'b0, c.setpoint_margin},
                    {3'b0, c.alarm_minutes_max}};
        for (int i = 0; i < 4; i++) begin
            @(negedge clk);
            cfg_ch.valid = 1'b1;
            cfg_ch.index = reg_idx[i];
            cfg_ch.data  = reg_val[i];
            do @(posedge clk); while (!cfg_ch.ready);
            case (reg_idx[i])
                REG_SETPOINT_MAX:    pm_cfg.setpoint_max      = reg_val[i];
                REG_SETPOINT_STEP:   pm_cfg.setpoint_step     = reg_val[i][7:0];
                REG_SETPOINT_MARGIN: pm_cfg.setpoint_margin   = reg_val[i][7:0];
                REG_ALARM_MIN_MAX:   pm_cfg.alarm_minutes_max = reg_val[i][7:0];
                default: ;
            endcase
        end
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // event request driver: bursts with random gaps, holds the request until taken
    always @(negedge clk) begin : drive_events
        t_event ev;
        if (rst_n && evt_offered == evt_accepted) begin
            if (gap_left > 0) begin
                gap_left--;
                evt_ch.valid <= 1'b0;
            end else if (panel_events.size() != 0) begin
                ev = panel_events.pop_front();
                evt_ch.valid         <= 1'b1;
                evt_ch.event_kind    <= ev.event_kind;
                evt_ch.button_status <= ev.button_status;
                evt_ch.temp_sample   <= ev.temp_sample;
                evt_offered++;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end else begin
                evt_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin : take_events
        t_event ev;
        if (rst_n && evt_ch.valid && evt_ch.ready) begin
            ev.event_kind    = evt_ch.event_kind;
            ev.button_status = evt_ch.button_status;
            ev.temp_sample   = evt_ch.temp_sample;
            expected_results.push_back(panel_update(ev));
            evt_accepted++;
        end
    end

    // result ready: changing stall patterns, plus a long hold-off while events queue up
    always @(negedge clk) begin : drive_ready
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            res_ch.ready <= 1'b0;
        end else if (rx_holds_done < 2 && results_seen >= rx_next_hold &&
                     panel_events.size() > 40) begin
            rx_hold_left = 90;
            rx_holds_done++;
            rx_next_hold += 300;
            res_ch.ready <= 1'b0;
        end else begin
            if (rx_pattern_left == 0) begin
                rx_pattern      = t_rx_pattern'($urandom_range(0, 3));
                rx_pattern_left = $urandom_range(16, 96);
            end else begin
                rx_pattern_left--;
            end
            case (rx_pattern)
                RX_FLOW:   res_ch.ready <= 1'b1;
                RX_COIN:   res_ch.ready <= ($urandom_range(0, 1) != 0);
                RX_SPARSE: res_ch.ready <= ($urandom_range(0, 3) == 0);
                default:   res_ch.ready <= ($urandom_range(0, 6) != 0);
            endcase
        end
    end

    task automatic check_field(input string fname, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch on %s at result %0d: expected %0h, got %0h",
                         fname, results_seen, want_v, got_v);
        end
    endtask

    always @(posedge clk) begin : check_results
        t_result want;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %0d, nothing pending", results_seen);
            end else begin
                want = expected_results.pop_front();
                check_field("running", want.running, res_ch.running);
                check_field("led_on", want.led_on, res_ch.led_on);
                check_field("buzzer_blinking", want.buzzer_blinking, res_ch.buzzer_blinking);
                check_field("timer_command", want.timer_command, res_ch.timer_command);
                check_field("setpoint", want.setpoint, res_ch.setpoint);
                check_field("measured_temp", want.measured_temp, res_ch.measured_temp);
                check_field("alarm_count", want.alarm_count, res_ch.alarm_count);
                check_field("alarm_list", want.alarm_list, res_ch.alarm_list);
                check_field("display_update", want.display_update, res_ch.display_update);
            end
        end
    end

    always @(posedge clk) begin : watchdog
        if ((evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WatchdogLimit) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        t_cfg c;
        clk = 1'b0;
        rst_n = 1'b0;
        evt_ch.valid = 1'b0;
        evt_ch.event_kind = EV_RUN_STOP;
        evt_ch.button_status = BTN_NONE;
        evt_ch.temp_sample = '0;
        res_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_SETPOINT_MAX;
        cfg_ch.data = '0;
        evt_offered = 0;
        evt_accepted = 0;
        results_seen = 0;
        mismatch_count = 0;
        idle_cycles = 0;
        burst_left = 0;
        gap_left = 0;
        rx_pattern = RX_FLOW;
        rx_pattern_left = 0;
        rx_hold_left = 0;
        rx_holds_done = 0;
        rx_next_hold = 150;
        reset_panel();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed walk through the countdown list, then stop mode and back
        queue_event(EV_TICK, BTN_NONE, 16'h0000);
        queue_event(EV_ADD, BTN_TAP, 16'h0000);
        queue_event(EV_ADD, BTN_HELD, 16'hFFFF);
        queue_event(EV_ALARM, BTN_HELD, 16'h0000);
        queue_event(EV_ADD, BTN_TAP, 16'h0000);
        queue_event(EV_ADD, BTN_ODD, 16'h0000);
        queue_event(EV_ADD, BTN_TAP, 16'h0000);
        queue_event(EV_ADD, BTN_TAP, 16'h0000);
        queue_event(EV_ADD, BTN_TAP, 16'h0000);
        queue_event(EV_SUB, BTN_TAP, 16'h0000);
        queue_event(EV_ALARM, BTN_NONE, 16'h0000);
        queue_event(EV_ADD, BTN_TAP, 16'h0000);
        queue_event(EV_SUB, BTN_ODD, 16'h0000);
        queue_event(EV_TICK, BTN_NONE, 16'h0000);
        queue_event(EV_TICK, BTN_HELD, 16'h0000);
        queue_event(EV_ALARM, BTN_TAP, 16'h0000);
        queue_event(EV_SAMPLE, BTN_NONE, 16'hFFFF);
        queue_event(EV_SPARE_LO, BTN_TAP, 16'h1234);
        queue_event(EV_SPARE_HI, BTN_HELD, 16'h0000);
        queue_event(EV_RUN_STOP, BTN_NONE, 16'h0000);
        queue_event(EV_RUN_STOP, BTN_TAP, 16'h0000);
        queue_event(EV_TICK, BTN_NONE, 16'h0000);
        queue_event(EV_ALARM, BTN_HELD, 16'h0000);
        queue_event(EV_SAMPLE, BTN_NONE, 16'h0000);
        queue_event(EV_ADD, BTN_TAP, 16'h0000);
        queue_event(EV_SUB, BTN_HELD, 16'h0000);
        queue_event(EV_RUN_STOP, BTN_ODD, 16'h0000);

        for (int phase = 0; phase < PhaseCount; phase++) begin
            if (phase > 0) begin
                wait_drained();
                case (phase)
                    1: c = '{setpoint_max: 11'd0, setpoint_step: 8'd255,
                             setpoint_margin: 8'd0, alarm_minutes_max: 8'd1};
                    2: c = '{setpoint_max: 11'd2047, setpoint_step: 8'd255,
                             setpoint_margin: 8'd255, alarm_minutes_max: 8'd255};
                    3: begin
                        c = random_cfg();
                        c.setpoint_step = 8'd1;
                    end
                    default: c = random_cfg();
                endcase
                write_config(c);
                if (phase == 1) begin
                    // step the setpoint down in stop mode, where a step below zero saturates at zero
                    if (pm_running) queue_event(EV_RUN_STOP, BTN_TAP, 16'h0000);
                    queue_event(EV_SAMPLE, BTN_NONE, 16'h0000);
                    queue_event(EV_SUB, BTN_TAP, 16'h0000);
                    queue_event(EV_SUB, BTN_HELD, 16'h0000);
                    queue_event(EV_SUB, BTN_ODD, 16'h0000);
                end
            end
            for (int n = 0; n < RandomPerPhase; n++)
                panel_events.push_back(random_event());
        end

        wait_drained();
        if (expected_results.size() != 0) mismatch_count++;
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
design/hpac_pkg.sv
design/hpac_if.sv
design/hpac_cfg_regs.sv
design/hpac_engine.sv
design/heater_panel_alarm_controller.sv
tb/tb_top.sv
